// File: sv/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 decoder.
// Holds the decoded-job type and the fixed coding constants. No dependencies.
package u8u16_pkg;

    localparam int ByteW    = 8;
    localparam int UnitW    = 16;
    localparam int PartialW = 15;
    localparam int ScalarW  = 21;
    localparam int OffsetW  = 26;

    localparam logic [ByteW-1:0]   LeadTwo   = 8'h80;
    localparam logic [ByteW-1:0]   LeadThree = 8'hE0;
    localparam logic [ByteW-1:0]   LeadFour  = 8'hF0;
    localparam logic [1:0]         SeqPair   = 2'd3;
    localparam logic [OffsetW-1:0] SuppBase  = 26'h0010000;
    localparam logic [UnitW-1:0]   HighBase  = 16'hD800;
    localparam logic [UnitW-1:0]   LowBase   = 16'hDC00;

    typedef struct packed {
        logic               pair;
        logic [ScalarW-1:0] scalar;
    } job_t;

endpackage

// File: sv/u8u16_queue.sv
// Small job queue between the decoder front and the unit emitter.
// Depends on u8u16_pkg for job_t.
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output job_t rd_job,
    output logic rd_valid
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    job_t            slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full     = (count_reg == FullCnt);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("job queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("job queue count out of range");

endmodule

// File: sv/u8u16_front.sv
// Byte classifier and sequence gatherer of the UTF-8 to UTF-16 decoder.
// Depends on u8u16_pkg; hands finished scalars to the job queue.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [ByteW-1:0] in_byte,
    input  logic             end_of_string,
    output logic             job_push,
    output job_t             job
);

    logic [1:0]          pending_reg;
    logic [1:0]          pending_next;
    logic [PartialW-1:0] partial_reg;
    logic [PartialW-1:0] partial_next;
    logic [1:0]          seq_len_reg;
    logic [1:0]          seq_len_next;
    logic [ScalarW-1:0]  gathered;
    logic [1:0]          pending_dec;

    assign gathered    = {partial_reg, in_byte[5:0]};
    assign pending_dec = pending_reg - 1'b1;

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        seq_len_next = seq_len_reg;
        job_push     = 1'b0;
        job.pair     = 1'b0;
        job.scalar   = gathered;
        if (accept)
        begin
            if (pending_reg == 2'd0)
            begin
                job.scalar = {{(ScalarW-ByteW){1'b0}}, in_byte};
                if (in_byte < LeadTwo)
                begin
                    job_push = 1'b1;
                end
                else if (in_byte < LeadThree)
                begin
                    partial_next = {{(PartialW-5){1'b0}}, in_byte[4:0]};
                    seq_len_next = 2'd1;
                    pending_next = 2'd1;
                end
                else if (in_byte < LeadFour)
                begin
                    partial_next = {{(PartialW-4){1'b0}}, in_byte[3:0]};
                    seq_len_next = 2'd2;
                    pending_next = 2'd2;
                end
                else
                begin
                    partial_next = {{(PartialW-3){1'b0}}, in_byte[2:0]};
                    seq_len_next = 2'd3;
                    pending_next = 2'd3;
                end
            end
            else
            begin
                pending_next = pending_dec;
                if (pending_dec == 2'd0)
                begin
                    job_push     = 1'b1;
                    job.pair     = (seq_len_reg == SeqPair);
                    partial_next = '0;
                    seq_len_next = 2'd0;
                end
                else
                begin
                    partial_next = gathered[PartialW-1:0];
                end
            end
            // drop any open sequence at end of string
            if (end_of_string)
            begin
                pending_next = 2'd0;
                partial_next = '0;
                seq_len_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            seq_len_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            seq_len_reg <= seq_len_next;
        end
    end

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> accept)
        else $error("job pushed without an accepted byte");
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd0 |-> seq_len_reg == 2'd0)
        else $error("sequence length left over while idle");
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= seq_len_reg)
        else $error("more bytes pending than sequence length");
    a_pair_final: assert property (@(posedge clk) disable iff (!rst_n)
        job_push && job.pair |-> pending_reg == 2'd1 && seq_len_reg == SeqPair)
        else $error("surrogate pair outside a four byte sequence");

endmodule

// File: sv/u8u16_back.sv
// Unit emitter of the UTF-8 to UTF-16 decoder: splits scalars into code units.
// Depends on u8u16_pkg; drains the job queue into a registered output stage.
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  job_t             job,
    output logic             job_pop,
    input  logic             pop,
    output logic             empty,
    output logic [UnitW-1:0] code_unit,
    output logic             last_unit
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [UnitW-1:0]   out_unit_reg;
    logic [UnitW-1:0]   out_unit_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               lo_valid_reg;
    logic               lo_valid_next;
    logic [UnitW-1:0]   lo_unit_reg;
    logic [UnitW-1:0]   lo_unit_next;
    logic               advance;
    logic [OffsetW-1:0] offset;
    logic [UnitW-1:0]   high_half;
    logic [UnitW-1:0]   low_half;

    assign offset    = {{(OffsetW-ScalarW){1'b0}}, job.scalar} - SuppBase;
    assign high_half = HighBase + offset[OffsetW-1:10];
    assign low_half  = LowBase + {{(UnitW-10){1'b0}}, offset[9:0]};

    assign advance = !out_valid_reg || pop;
    assign job_pop = advance && !lo_valid_reg && job_valid;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_unit_next  = out_unit_reg;
        out_last_next  = out_last_reg;
        lo_valid_next  = lo_valid_reg;
        lo_unit_next   = lo_unit_reg;
        if (advance)
        begin
            if (lo_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_unit_next  = lo_unit_reg;
                out_last_next  = 1'b1;
                lo_valid_next  = 1'b0;
            end
            else if (job_valid)
            begin
                out_valid_next = 1'b1;
                if (job.pair)
                begin
                    out_unit_next = high_half;
                    out_last_next = 1'b0;
                    lo_valid_next = 1'b1;
                    lo_unit_next  = low_half;
                end
                else
                begin
                    out_unit_next = job.scalar[UnitW-1:0];
                    out_last_next = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            lo_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            lo_valid_reg  <= lo_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_unit_reg <= out_unit_next;
        out_last_reg <= out_last_next;
        lo_unit_reg  <= lo_unit_next;
    end

    assign empty     = !out_valid_reg;
    assign code_unit = out_unit_reg;
    assign last_unit = out_last_reg;

    a_low_behind_high: assert property (@(posedge clk) disable iff (!rst_n)
        lo_valid_reg |-> out_valid_reg && !out_last_reg)
        else $error("low surrogate held without its high half on the output");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_unit_reg))
        else $error("output unit changed while stalled");
    a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        lo_valid_reg && pop |=> out_last_reg && !lo_valid_reg)
        else $error("low surrogate not issued after high half");

endmodule

// File: sv/utf8_to_utf16_stream_decoder_unit.sv
// Streaming UTF-8 to UTF-16 decoder: takes one byte per cycle while the job
// queue is not full and returns one code unit per cycle while pop is held,
// from a registered output. A byte that ends a sequence yields one unit, or
// two for a surrogate pair; bytes inside a sequence yield none. A surrogate
// pair holds the unit emitter for both halves, absorbed by the job queue of
// QUEUE_DEPTH entries. An ending byte is registered in the job queue, then in
// the output register. An accepted end_of_string drops any open sequence.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back.
module utf8_to_utf16_stream_decoder_unit
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [ByteW-1:0] in_byte,
    input  logic             end_of_string,
    output logic             empty,
    input  logic             pop,
    output logic [UnitW-1:0] code_unit,
    output logic             last_unit
);

    logic accept;
    logic job_push;
    job_t job_in;
    logic job_pop;
    job_t job_out;
    logic job_valid;
    logic queue_full;

    assign full   = queue_full;
    assign accept = push && !queue_full;

    u8u16_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .job_push      (job_push),
        .job           (job_in)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (job_in),
        .full     (queue_full),
        .rd_en    (job_pop),
        .rd_job   (job_out),
        .rd_valid (job_valid)
    );

    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .pop       (pop && !empty),
        .empty     (empty),
        .code_unit (code_unit),
        .last_unit (last_unit)
    );

endmodule
